// ===== hw/rtl/ttl_hash_cache_tags_top_defines.svh =====
// Assertion macros shared by the tag cache RTL.
`ifndef TTL_HASH_CACHE_TAGS_TOP_DEFINES_SVH
`define TTL_HASH_CACHE_TAGS_TOP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define TTL_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define TTL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ttl_pkg.sv =====
// Package: sizes, codes and helpers for the TTL tag cache.
`timescale 1ns / 1ps
package ttl_pkg;

   localparam int SLOTS   = 8;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SLOT_W  = 3;
   localparam int HASH_W  = 32;
   localparam int TIME_W  = 63;
   localparam int TTL_W   = 40;
   localparam int ENTRY_W = HASH_W + TIME_W;

   localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(300000000);

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_STORE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   // Low bits of a slot index as carried in a result beat.
   function automatic logic [SLOT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/ttl_if.sv =====
// Request and response channel interfaces of the TTL tag cache.
`timescale 1ns / 1ps
interface ttl_req_if;
   import ttl_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [HASH_W-1:0] key_hash;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, output func, output key_hash, output now_time,
                   input ready);
   modport sink   (input valid, input func, input key_hash, input now_time,
                   output ready);
endinterface

interface ttl_rsp_if;
   import ttl_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic              replaced_live;

   modport source (output valid, output hit, output slot, output replaced_live,
                   input ready);
   modport sink   (input valid, input hit, input slot, input replaced_live,
                   output ready);
endinterface

// ===== hw/rtl/ttl_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ttl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ttl_hash_cache_tags_top.sv =====
// Flow: a store into an empty slot writes it on accept and goes straight to the result beat;
// lookup and store into a full table walk the tag RAM one slot per cycle through
// its single read port, a lookup stopping at the first live match.
// Requests: one item at a time, req ready only in idle; the result register may wait
// on rsp ready before the next accept.
// Reset: synchronous, clears all valid bits and the result beat, loads the TTL
// register with 300000000; the tag RAM itself keeps no reset.
`timescale 1ns / 1ps
`include "ttl_hash_cache_tags_top_defines.svh"
module ttl_hash_cache_tags_top (
   input  logic                     clock,
   input  logic                     reset,
   ttl_req_if.sink                  req_chan,
   ttl_rsp_if.source                rsp_chan,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ttl_pkg::TTL_W-1:0] csr_data
);
   import ttl_pkg::*;

   state_type         state_ff, state_in;
   logic              func_ff, func_in;
   logic [HASH_W-1:0] key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W:0]    issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_time_ff, best_time_in;
   logic              res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_repl_ff, res_repl_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [TTL_W-1:0]  ttl_ff, ttl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_repl_ff, rsp_repl_in;

   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   logic [HASH_W-1:0] rd_hash;
   logic [TIME_W-1:0] rd_time;
   logic [TIME_W:0]   expire_at;
   logic              live_match, older, cmp_last, any_free;
   logic [IDX_W-1:0]  free_idx, pick_idx;

   ttl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_hash = ram_rd_data[ENTRY_W-1 -: HASH_W];
   assign rd_time = ram_rd_data[TIME_W-1:0];

   // age < ttl is the same as now < stamp + ttl, also when time ran backwards
   assign expire_at  = {1'b0, rd_time} + (TIME_W+1)'(ttl_ff);
   assign live_match = valid_ff[cmp_idx_ff] && (rd_hash == key_ff) && (ttl_ff != '0) &&
                       ({1'b0, now_ff} < expire_at);
   assign older      = (cmp_idx_ff == '0) || (rd_time < best_time_ff);
   assign pick_idx   = older ? cmp_idx_ff : best_idx_ff;
   assign cmp_last   = (cmp_idx_ff == IDX_W'(SLOTS-1));
   assign any_free   = !(&valid_ff);

   always_comb begin
      free_idx = '0;
      for (int i = SLOTS-1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.slot       = rsp_slot_ff;
   assign rsp_chan.replaced_live = rsp_repl_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      res_repl_in  = res_repl_ff;
      valid_in     = valid_ff;
      ttl_in       = ttl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_repl_in  = rsp_repl_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pick_idx;
      ram_wr_data  = {key_ff, now_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[IDX_W-1:0];

      if (csr_valid) begin
         ttl_in = csr_data;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in  = req_chan.func;
               key_in   = req_chan.key_hash;
               now_in   = req_chan.now_time;
               issue_in = '0;
               if (req_chan.func == FUNC_STORE && any_free) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_idx;
                  ram_wr_data        = {req_chan.key_hash, req_chan.now_time};
                  valid_in[free_idx] = 1'b1;
                  res_hit_in         = 1'b0;
                  res_slot_in        = slot_code(free_idx);
                  res_repl_in        = 1'b0;
                  state_in           = ST_OUT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read one slot per cycle, compare it the cycle after
            if (issue_ff < (IDX_W+1)'(SLOTS)) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[IDX_W-1:0];
            end
            if (cmp_valid_ff) begin
               if (func_ff == FUNC_LOOKUP) begin
                  if (live_match) begin
                     res_hit_in  = 1'b1;
                     res_slot_in = slot_code(cmp_idx_ff);
                     res_repl_in = 1'b0;
                     state_in    = ST_OUT;
                  end else if (cmp_last) begin
                     res_hit_in  = 1'b0;
                     res_slot_in = '0;
                     res_repl_in = 1'b0;
                     state_in    = ST_OUT;
                  end
               end else begin
                  // table is full here: track the oldest stamp, ties keep the lower slot
                  if (older) begin
                     best_idx_in  = cmp_idx_ff;
                     best_time_in = rd_time;
                  end
                  if (cmp_last) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = pick_idx;
                     res_hit_in  = 1'b0;
                     res_slot_in = slot_code(pick_idx);
                     res_repl_in = 1'b1;
                     state_in    = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_repl_in  = res_repl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         ttl_ff       <= TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         valid_ff     <= valid_in;
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      res_repl_ff  <= res_repl_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_repl_ff  <= rsp_repl_in;
   end

   `TTL_ASSERT_IMPL(a_write_only_store, ram_wr_en, (state_ff == ST_IDLE && req_chan.func == FUNC_STORE) || (state_ff == ST_SCAN && func_ff == FUNC_STORE), "tag RAM written outside a store")
   `TTL_ASSERT_NEXT(a_written_slot_valid, ram_wr_en, valid_ff[$past(ram_wr_addr)], "written slot not marked valid")
   `TTL_ASSERT_ALWAYS(a_issue_bound, issue_ff <= (IDX_W+1)'(SLOTS), "scan read index ran past the table")
   `TTL_ASSERT_ALWAYS(a_no_rw_overlap, !(ram_wr_en && ram_rd_en), "tag RAM read and write in the same cycle")

endmodule
